@@ design/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 digest engine: command and status
// groups exchanged by the controller, byte source codes, round phases.
// ----------------------------------------------------------------------------
package sha1_pkg;

    typedef logic [4:0][31:0] chain_t;

    localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

    localparam logic [5:0] LAST_POS    = 6'd63;
    localparam logic [5:0] PAD_END_POS = 6'd55;
    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam logic [2:0] LAST_WORD   = 3'd4;

    typedef enum logic [1:0] {
        SEL_MSG  = 2'd0,
        SEL_PAD  = 2'd1,
        SEL_ZERO = 2'd2,
        SEL_LEN  = 2'd3
    } byte_sel_t;

    typedef enum logic [1:0] {
        PH_CH   = 2'd0,
        PH_PAR0 = 2'd1,
        PH_MAJ  = 2'd2,
        PH_PAR1 = 2'd3
    } phase_t;

    typedef struct packed {
        logic      load_byte;
        byte_sel_t byte_sel;
        logic      start_blk;
        logic      round;
        phase_t    phase;
        logic      finish_blk;
        logic      restart;
        logic      out_load;
    } sha1_cmd_t;

    typedef struct packed {
        logic [5:0] fill_pos;
        logic       out_busy;
    } sha1_stat_t;

endpackage

@@ design/sha1_if.sv @@
// ----------------------------------------------------------------------------
// sha1_if
// Valid/ready channels of the SHA-1 engine: message bytes in, digest words out.
// ----------------------------------------------------------------------------
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, data_byte, has_byte, last, input ready);
    modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ design/sha1_dp.sv @@
// ----------------------------------------------------------------------------
// sha1_dp
// Datapath: 512-bit message/schedule window, round registers a..e, chaining
// words, byte and fill counters. Driven by commands from the controller.
// ----------------------------------------------------------------------------
module sha1_dp
    import sha1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sha1_cmd_t  cmd,
    input  logic [7:0] data_byte,
    output logic [5:0] fill_pos,
    output chain_t     chain
);

    chain_t        chain_reg, chain_next;
    chain_t        work_reg, work_next;
    logic [511:0]  win_reg, win_next;
    logic [60:0]   byte_count_reg, byte_count_next;
    logic [5:0]    fill_reg, fill_next;

    logic [63:0]   len_bits;
    logic [7:0]    byte_val;
    logic [31:0]   w_cur;
    logic [31:0]   w_new;
    logic [31:0]   f_val;
    logic [31:0]   k_val;
    logic [31:0]   tmp;
    logic [31:0]   a, b, c, d, e;

    function automatic logic [31:0] round_k(phase_t ph);
        logic [31:0] k;
        unique case (ph)
            PH_CH:   k = 32'h5A827999;
            PH_PAR0: k = 32'h6ED9EBA1;
            PH_MAJ:  k = 32'h8F1BBCDC;
            PH_PAR1: k = 32'hCA62C1D6;
            default: k = 32'h5A827999;
        endcase
        return k;
    endfunction

    assign len_bits = {byte_count_reg, 3'b000};

    // length bytes go out big-endian, indexed by the low fill bits
    always_comb
    begin
        unique case (cmd.byte_sel)
            SEL_MSG:  byte_val = data_byte;
            SEL_PAD:  byte_val = 8'h80;
            SEL_ZERO: byte_val = 8'h00;
            SEL_LEN:  byte_val = len_bits[{~fill_reg[2:0], 3'b000} +: 8];
            default:  byte_val = 8'h00;
        endcase
    end

    assign a = work_reg[0];
    assign b = work_reg[1];
    assign c = work_reg[2];
    assign d = work_reg[3];
    assign e = work_reg[4];

    // window word 0 is w[t]; taps at 2, 8 and 13 give w[t+16]
    assign w_cur = win_reg[511:480];
    always_comb
    begin
        w_new = win_reg[95:64] ^ win_reg[255:224] ^ win_reg[447:416] ^ w_cur;
        w_new = {w_new[30:0], w_new[31]};
    end

    always_comb
    begin
        case (cmd.phase)
            PH_CH:   f_val = (b & c) | (~b & d);
            PH_MAJ:  f_val = (b & c) | (b & d) | (c & d);
            default: f_val = b ^ c ^ d;
        endcase
    end

    assign k_val = round_k(cmd.phase);
    assign tmp   = {a[26:0], a[31:27]} + f_val + e + k_val + w_cur;

    always_comb
    begin
        win_next = win_reg;
        if (cmd.load_byte)
            win_next = {win_reg[503:0], byte_val};
        else if (cmd.round)
            win_next = {win_reg[479:0], w_new};
    end

    always_comb
    begin
        work_next = work_reg;
        if (cmd.start_blk)
            work_next = chain_reg;
        else if (cmd.round)
            work_next = {d, c, {b[1:0], b[31:2]}, a, tmp};
    end

    always_comb
    begin
        chain_next = chain_reg;
        if (cmd.restart)
            chain_next = H_INIT;
        else if (cmd.finish_blk)
            for (int i = 0; i < 5; i++)
                chain_next[i] = chain_reg[i] + work_reg[i];
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        fill_next       = fill_reg;
        if (cmd.restart)
        begin
            byte_count_next = '0;
            fill_next       = '0;
        end
        else if (cmd.load_byte)
        begin
            fill_next = fill_reg + 6'd1;
            if (cmd.byte_sel == SEL_MSG)
                byte_count_next = byte_count_reg + 61'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg      <= H_INIT;
            byte_count_reg <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            chain_reg      <= chain_next;
            byte_count_reg <= byte_count_next;
            fill_reg       <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        work_reg <= work_next;
    end

    assign fill_pos = fill_reg;
    assign chain    = chain_reg;

endmodule

@@ design/sha1_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha1_ctrl
// Controller: takes message bytes, sequences padding and length bytes,
// counts the 80 rounds of each block and hands the digest to the output stage.
// ----------------------------------------------------------------------------
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sha1_in_if.sink       msg,
    input  sha1_stat_t    stat,
    output sha1_cmd_t     cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_ZERO  = 7'b0000100,
        ST_LEN   = 7'b0001000,
        ST_ROUND = 7'b0010000,
        ST_FOLD  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [6:0] round_reg, round_next;

    assign msg.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.byte_sel = SEL_MSG;
        if (round_reg < 7'd20)
            cmd.phase = PH_CH;
        else if (round_reg < 7'd40)
            cmd.phase = PH_PAR0;
        else if (round_reg < 7'd60)
            cmd.phase = PH_MAJ;
        else
            cmd.phase = PH_PAR1;

        state_next = state_reg;
        ret_next   = ret_reg;
        round_next = round_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    if (msg.has_byte)
                    begin
                        cmd.load_byte = 1'b1;
                        if (stat.fill_pos == LAST_POS)
                        begin
                            cmd.start_blk = 1'b1;
                            state_next    = ST_ROUND;
                            ret_next      = msg.last ? ST_PAD : ST_IDLE;
                        end
                        else if (msg.last)
                            state_next = ST_PAD;
                    end
                    else if (msg.last)
                        state_next = ST_PAD;
                end
            end
            ST_PAD, ST_ZERO:
            begin
                cmd.load_byte = 1'b1;
                cmd.byte_sel  = (state_reg == ST_PAD) ? SEL_PAD : SEL_ZERO;
                if (stat.fill_pos == LAST_POS)
                begin
                    // no room for the length: finish this block, pad another
                    cmd.start_blk = 1'b1;
                    state_next    = ST_ROUND;
                    ret_next      = ST_ZERO;
                end
                else if (stat.fill_pos == PAD_END_POS)
                    state_next = ST_LEN;
                else
                    state_next = ST_ZERO;
            end
            ST_LEN:
            begin
                cmd.load_byte = 1'b1;
                cmd.byte_sel  = SEL_LEN;
                if (stat.fill_pos == LAST_POS)
                begin
                    cmd.start_blk = 1'b1;
                    state_next    = ST_ROUND;
                    ret_next      = ST_DONE;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (round_reg == LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = ST_FOLD;
                end
                else
                    round_next = round_reg + 7'd1;
            end
            ST_FOLD:
            begin
                cmd.finish_blk = 1'b1;
                state_next     = ret_reg;
            end
            ST_DONE:
            begin
                // wait until the previous digest has fully drained
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.restart  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
        end
    end

endmodule

@@ design/sha1_out.sv @@
// ----------------------------------------------------------------------------
// sha1_out
// Output stage: holds a finished digest and presents it as five words, h0
// first, so the core can take the next message while the receiver stalls.
// ----------------------------------------------------------------------------
module sha1_out
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  chain_t      chain,
    output logic        busy,
    sha1_out_if.source  digest
);

    chain_t     buf_reg, buf_next;
    logic       valid_reg, valid_next;
    logic [2:0] idx_reg, idx_next;
    logic       take;

    assign take = valid_reg && digest.ready;

    always_comb
    begin
        buf_next   = buf_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            buf_next   = chain;
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (take)
        begin
            buf_next = {32'h0, buf_reg[4:1]};
            if (idx_reg == LAST_WORD)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign digest.valid       = valid_reg;
    assign digest.digest_word = buf_reg[0];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == LAST_WORD);
    assign busy               = valid_reg;

endmodule

@@ design/sha1_hash.sv @@
// ----------------------------------------------------------------------------
// sha1_hash
// SHA-1 digest engine, top level.
// ----------------------------------------------------------------------------
// msg carries one message byte per transaction (data_byte, has_byte, last).
// A transaction with has_byte low and last high ends the message; one with
// both low is ignored. digest returns five transactions per message, h0 to h4,
// with word_index and last_word marking the fifth.
// Bytes are taken one per cycle while the controller is idle; the 64th byte of
// a block starts an 80-round compression (one round per cycle on the shared
// round unit) followed by a fold into the chaining words, during which no bytes
// are taken. After last, padding and length bytes are inserted one per cycle up
// to the block end, taking one or two more compressions; after the final fold
// the done state loads the digest into the output register once it is free.
// The digest sits in an output register, so the next message is taken while
// the receiver stalls; only a second digest waits until the first has drained.
// Reset restores the initial chaining values and clears counters and valid.
// ----------------------------------------------------------------------------
module sha1_hash
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sha1_in_if.sink     msg,
    sha1_out_if.source  digest
);

    sha1_cmd_t  cmd;
    sha1_stat_t stat;
    logic [5:0] fill_pos;
    logic       out_busy;
    chain_t     chain;

    assign stat.fill_pos = fill_pos;
    assign stat.out_busy = out_busy;

    sha1_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .stat  (stat),
        .cmd   (cmd)
    );

    sha1_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (msg.data_byte),
        .fill_pos  (fill_pos),
        .chain     (chain)
    );

    sha1_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (cmd.out_load),
        .chain  (chain),
        .busy   (out_busy),
        .digest (digest)
    );

endmodule

@@ tb/tb_sha1_hash.sv @@
// ----------------------------------------------------------------------------
// tb_sha1_hash
// Self-checking bench for the SHA-1 digest engine. Byte transactions are fed
// from a pending queue, a local SHA-1 predictor computes the five digest words
// of every finished message, and each digest transaction is checked against
// the oldest predicted word. Handshakes idle at random in two of three phases,
// with one long receiver hold-off that backs the engine up to its input.
// ----------------------------------------------------------------------------
module tb_sha1_hash
    import sha1_pkg::*;
();

    localparam logic [31:0] K_CH   = 32'h5A827999;
    localparam logic [31:0] K_PAR0 = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR1 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam int          STALL_LIMIT = 5000;
    localparam int          TAIL_CYCLES = 300;
    localparam int          HOLD_CYCLES = 800;

    typedef struct {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } msg_item_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last_word;
    } digest_word_t;

    logic clk = 1'b0;
    logic rst_n;

    sha1_in_if  msg_if ();
    sha1_out_if dig_if ();

    sha1_hash u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .digest (dig_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    msg_item_t    byte_q[$];
    digest_word_t digest_exp_q[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_cycles;
    int check_errors;
    int stall_count;
    logic byte_taken;

    // predictor state
    logic [31:0] h_state [5];
    logic [31:0] blk_words [16];
    logic [60:0] msg_len;

    function automatic void hash_restart();
        for (int i = 0; i < 5; i++)
            h_state[i] = H_INIT[i];
        for (int i = 0; i < 16; i++)
            blk_words[i] = '0;
        msg_len = '0;
    endfunction

    function automatic void put_byte(logic [5:0] pos, logic [7:0] v);
        int sh;
        sh = (3 - int'(pos[1:0])) * 8;
        blk_words[pos[5:2]][sh +: 8] = v;
    endfunction

    // schedule is expanded in a local window so gathered bytes stay untouched
    function automatic void sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        w = blk_words;
        a = h_state[0];
        b = h_state[1];
        c = h_state[2];
        d = h_state[3];
        e = h_state[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t >= 16)
            begin
                tmp = w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15];
                w[t & 15] = {tmp[30:0], tmp[31]};
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = K_PAR0;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_PAR1;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + w[t & 15];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        h_state[0] += a;
        h_state[1] += b;
        h_state[2] += c;
        h_state[3] += d;
        h_state[4] += e;
    endfunction

    function automatic void sha1_absorb(logic [7:0] data, logic has, logic fin);
        logic [5:0]   pos;
        logic [63:0]  bit_len;
        digest_word_t dw;
        if (has)
        begin
            pos = msg_len[5:0];
            put_byte(pos, data);
            msg_len = msg_len + 1'b1;
            if (pos == LAST_POS)
                sha1_compress();
        end
        if (!fin)
            return;
        pos = msg_len[5:0];
        put_byte(pos, PAD_BYTE);
        for (int i = int'(pos) + 1; i < 64; i++)
            put_byte(6'(i), 8'h00);
        // no room for the length field, so an extra padding block
        if (pos > PAD_END_POS)
        begin
            sha1_compress();
            for (int i = 0; i < 16; i++)
                blk_words[i] = '0;
        end
        bit_len = {msg_len, 3'b000};
        blk_words[14] = bit_len[63:32];
        blk_words[15] = bit_len[31:0];
        sha1_compress();
        for (int i = 0; i < 5; i++)
        begin
            dw.word      = h_state[i];
            dw.index     = 3'(i);
            dw.last_word = (3'(i) == LAST_WORD);
            digest_exp_q = {digest_exp_q, dw};
        end
        hash_restart();
    endfunction

    // sender: one transaction held until taken, with random idle gaps between them
    always @(negedge clk)
    begin
        msg_item_t it;
        if (rst_n && (!msg_if.valid || byte_taken))
        begin
            if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                it = byte_q.pop_front();
                msg_if.valid     <= 1'b1;
                msg_if.data_byte <= it.data_byte;
                msg_if.has_byte  <= it.has_byte;
                msg_if.last      <= it.last;
            end
            else
                msg_if.valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus a counted hold-off when requested
    always @(negedge clk)
    begin
        if (!rst_n)
            dig_if.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            dig_if.ready <= 1'b0;
        end
        else
            dig_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        digest_word_t want;
        logic         in_hs;
        logic         out_hs;
        in_hs  = rst_n && msg_if.valid && msg_if.ready;
        out_hs = rst_n && dig_if.valid && dig_if.ready;
        byte_taken <= in_hs;
        if (in_hs)
            sha1_absorb(msg_if.data_byte, msg_if.has_byte, msg_if.last);
        if (out_hs)
        begin
            if (digest_exp_q.size() == 0)
            begin
                if (check_errors < 10)
                    $display("digest word %08h idx %0d with no message pending",
                             dig_if.digest_word, dig_if.word_index);
                check_errors++;
            end
            else
            begin
                want = digest_exp_q.pop_front();
                if (dig_if.digest_word !== want.word || dig_if.word_index !== want.index
                    || dig_if.last_word !== want.last_word)
                begin
                    if (check_errors < 10)
                        $display("digest mismatch: exp %08h/%0d/%0b got %08h/%0d/%0b",
                                 want.word, want.index, want.last_word,
                                 dig_if.digest_word, dig_if.word_index, dig_if.last_word);
                    check_errors++;
                end
            end
        end
        if (!rst_n || in_hs || out_hs)
            stall_count = 0;
        else
        begin
            stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", stall_count);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic push_item(logic [7:0] d, logic has, logic fin);
        msg_item_t it;
        it.data_byte = d;
        it.has_byte  = has;
        it.last      = fin;
        byte_q = {byte_q, it};
    endtask

    // random messages: mostly short, some on the padding boundaries, a few long
    task automatic queue_random(int n_items);
        int  count;
        int  len;
        int  sel;
        bit  end_alone;
        int  edge_len [6] = '{55, 56, 57, 63, 64, 65};
        count = 0;
        while (count < n_items)
        begin
            sel = $urandom_range(9);
            if (sel <= 5)
                len = $urandom_range(1, 20);
            else if (sel <= 7)
                len = edge_len[$urandom_range(5)];
            else if (sel == 8)
                len = $urandom_range(66, 130);
            else
                len = 0;
            end_alone = (len == 0) || ($urandom_range(4) == 0);
            for (int i = 0; i < len; i++)
            begin
                // stray idle transaction now and then
                if ($urandom_range(19) == 0)
                    push_item(8'($urandom_range(255)), 1'b0, 1'b0);
                push_item(8'($urandom_range(255)), 1'b1, !end_alone && (i == len - 1));
            end
            if (end_alone)
                push_item(8'($urandom_range(255)), 1'b0, 1'b1);
            count += len + int'(end_alone);
        end
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || msg_if.valid || digest_exp_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        msg_if.valid     = 1'b0;
        msg_if.data_byte = '0;
        msg_if.has_byte  = 1'b0;
        msg_if.last      = 1'b0;
        dig_if.ready     = 1'b0;
        byte_taken       = 1'b0;
        hold_cycles      = 0;
        check_errors     = 0;
        stall_count      = 0;
        tx_idle_pct      = 29;
        rx_idle_pct      = 72;
        hash_restart();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, then an idle transaction
        push_item(8'h5A, 1'b0, 1'b1);
        push_item(8'h00, 1'b0, 1'b0);
        // "abc", last mark on the final byte
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        // single-byte extremes
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1);
        // idle mid-message, then a byteless end
        push_item(8'hA5, 1'b1, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h3C, 1'b1, 1'b0);
        push_item(8'hFF, 1'b0, 1'b1);
        // two empty messages back to back
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b1);

        queue_random(145);
        wait_drained();

        tx_idle_pct = 72;
        rx_idle_pct = 29;
        queue_random(155);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random(160);
        hold_cycles = HOLD_CYCLES;
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (digest_exp_q.size() != 0)
            check_errors += digest_exp_q.size();
        if (check_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
design/sha1_pkg.sv
design/sha1_if.sv
design/sha1_dp.sv
design/sha1_ctrl.sv
design/sha1_out.sv
design/sha1_hash.sv
tb/tb_sha1_hash.sv
